@@ rtl/core/lrip_pkg.sv @@
// Shared types, constants and the arctangent table of the range-image projection unit.
package lrip_pkg;

  localparam int MAX_ROWS_DEF     = 64;
  localparam int MAX_COLUMNS_DEF  = 2048;
  localparam int COORD_WIDTH_DEF  = 24;
  localparam int CORDIC_STEPS_DEF = 20;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // angle words, radians scaled by 2^20
  localparam int ANG_W       = 24;
  localparam int CORDIC_W    = 64;
  localparam int HALF_PI_Q20 = 1647099;

  // divider operand widths
  localparam int DIV_N = 26;
  localparam int DIV_D = 24;

  // internal row, column and count widths
  localparam int ROW_IN_W  = 8;
  localparam int COL_IN_W  = 12;
  localparam int ROWS_W    = 9;
  localparam int COLS_W    = 13;
  localparam int COLSIG_W  = 29;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 11;
  localparam int CELL_W  = 17;
  localparam int RANGE_W = 24;

  localparam logic [6:0]         ROW_COUNT_RST       = 7'd16;
  localparam logic [11:0]        COLUMN_COUNT_RST    = 12'd1800;
  localparam logic signed [21:0] BOTTOM_OFFSET_RST   = 22'sd276346;
  localparam logic [20:0]        VERTICAL_STEP_RST   = 21'd36602;
  localparam logic [22:0]        HORIZONTAL_STEP_RST = 23'd3660;
  localparam logic [22:0]        MIN_RANGE_RST       = 23'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT       = 3'd0,
    REG_COLUMN_COUNT    = 3'd1,
    REG_BOTTOM_OFFSET   = 3'd2,
    REG_VERTICAL_STEP   = 3'd3,
    REG_HORIZONTAL_STEP = 3'd4,
    REG_MIN_RANGE       = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ROW_OUT  = 2'd1,
    ST_COL_OUT  = 2'd2,
    ST_TOO_NEAR = 2'd3
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     column;
    logic [CELL_W-1:0]    cell_index;
    logic [RANGE_W-1:0]   range;
  } res_t;

  // atan(2^-i) scaled by 2^20, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q20(input int idx);
    case (idx)
      0:  return 24'sd823550;
      1:  return 24'sd486170;
      2:  return 24'sd256879;
      3:  return 24'sd130396;
      4:  return 24'sd65451;
      5:  return 24'sd32757;
      6:  return 24'sd16383;
      7:  return 24'sd8192;
      8:  return 24'sd4096;
      9:  return 24'sd2048;
      10: return 24'sd1024;
      11: return 24'sd512;
      12: return 24'sd256;
      13: return 24'sd128;
      14: return 24'sd64;
      15: return 24'sd32;
      16: return 24'sd16;
      17: return 24'sd8;
      18: return 24'sd4;
      19: return 24'sd2;
      20: return 24'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

@@ rtl/core/lrip_in_if.sv @@
// Point input channel: valid, ready and the three coordinates.
interface lrip_in_if #(
  parameter int COORD_WIDTH = lrip_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

@@ rtl/core/lrip_out_if.sv @@
// Result channel: valid, ready and the projected cell.
interface lrip_out_if ();
  logic                           valid;
  logic                           ready;
  lrip_pkg::status_t              status;
  logic [lrip_pkg::ROW_W-1:0]     row;
  logic [lrip_pkg::COL_W-1:0]     column;
  logic [lrip_pkg::CELL_W-1:0]    cell_index;
  logic [lrip_pkg::RANGE_W-1:0]   range;

  modport source (output valid, status, row, column, cell_index, range, input ready);
  modport sink   (input valid, status, row, column, cell_index, range, output ready);
endinterface

@@ rtl/core/lidar_range_image_projection_unit.sv @@
// Lidar point to range-image cell projection, fully pipelined.
// Usage:
//  in_pt carries one point (x, y, z, metres * 256) per transaction; out_res carries
//  one result per point, in order: status, row, column, flat cell index and range.
//  cfg_we / cfg_index / cfg_wdata write the six geometry registers; write them only
//  while no point is in flight.
// Pipeline: two multiply/add stages, a one-bit-per-stage square root (COORD_WIDTH + 1
//  stages), the CORDIC (CORDIC_STEPS + 1 stages), the dividend stage C, a
//  one-bit-per-stage divider (26 stages), stages D and E and the output queue.
// Throughput: one point per cycle while the pipeline is not stalled; every stage
//  registers a new item each cycle in which the pipeline advances.
// Reset: rst_n (synchronous) empties the pipeline and the output queue and loads the
//  register defaults (16 rows, 1800 columns, standard offset and steps, 2 m minimum).
// Stall: a two-entry output queue absorbs results; in_pt.ready stays high while it
//  has a free entry or out_res.ready is high, and the whole pipeline holds otherwise.
module lidar_range_image_projection_unit #(
  parameter int MAX_ROWS     = lrip_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS  = lrip_pkg::MAX_COLUMNS_DEF,
  parameter int COORD_WIDTH  = lrip_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = lrip_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lrip_in_if.sink                         in_pt,
  lrip_out_if.source                      out_res,
  input  logic                            cfg_we,
  input  logic [lrip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrip_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  localparam int CW     = COORD_WIDTH;
  localparam int RAD_W  = 2 * CW + 2;
  localparam int ROOT_W = CW + 1;
  localparam int AW     = lrip_pkg::ANG_W;
  localparam int DN     = lrip_pkg::DIV_N;
  localparam int DD     = lrip_pkg::DIV_D;
  localparam int RW     = lrip_pkg::ROW_IN_W;
  localparam int KW     = lrip_pkg::COL_IN_W;
  localparam int SW     = lrip_pkg::COLSIG_W;

  // configuration registers
  logic [6:0]         row_count_r;
  logic [11:0]        column_count_r;
  logic signed [21:0] bottom_offset_r;
  logic [20:0]        vertical_step_r;
  logic [22:0]        horizontal_step_r;
  logic [22:0]        min_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r       <= lrip_pkg::ROW_COUNT_RST;
      column_count_r    <= lrip_pkg::COLUMN_COUNT_RST;
      bottom_offset_r   <= lrip_pkg::BOTTOM_OFFSET_RST;
      vertical_step_r   <= lrip_pkg::VERTICAL_STEP_RST;
      horizontal_step_r <= lrip_pkg::HORIZONTAL_STEP_RST;
      min_range_r       <= lrip_pkg::MIN_RANGE_RST;
    end else if (cfg_we) begin
      unique case (lrip_pkg::cfg_reg_t'(cfg_index))
        lrip_pkg::REG_ROW_COUNT:       row_count_r       <= cfg_wdata[6:0];
        lrip_pkg::REG_COLUMN_COUNT:    column_count_r    <= cfg_wdata[11:0];
        lrip_pkg::REG_BOTTOM_OFFSET:   bottom_offset_r   <= $signed(cfg_wdata[21:0]);
        lrip_pkg::REG_VERTICAL_STEP:   vertical_step_r   <= cfg_wdata[20:0];
        lrip_pkg::REG_HORIZONTAL_STEP: horizontal_step_r <= cfg_wdata[22:0];
        lrip_pkg::REG_MIN_RANGE:       min_range_r       <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  // clamp counts to the image size
  logic [lrip_pkg::ROWS_W-1:0] rows;
  logic [lrip_pkg::COLS_W-1:0] cols;
  assign rows = (lrip_pkg::ROWS_W'(row_count_r) > lrip_pkg::ROWS_W'(MAX_ROWS)) ?
                lrip_pkg::ROWS_W'(MAX_ROWS) : lrip_pkg::ROWS_W'(row_count_r);
  assign cols = (lrip_pkg::COLS_W'(column_count_r) > lrip_pkg::COLS_W'(MAX_COLUMNS)) ?
                lrip_pkg::COLS_W'(MAX_COLUMNS) : lrip_pkg::COLS_W'(column_count_r);

  // output queue and global advance
  lrip_pkg::res_t head_r, tail_r, res_nxt;
  logic [1:0]     cnt_r;
  logic           adv;
  logic           pop;
  logic           push;

  assign adv         = (cnt_r != 2'd2) || out_res.ready;
  assign in_pt.ready = adv;

  // stage A: squares
  logic                 a_v_r;
  logic signed [CW-1:0] a_x_r, a_y_r, a_z_r;
  logic [2*CW-1:0]      a_sqx_r, a_sqy_r, a_sqz_r;
  logic signed [2*CW-1:0] px, py, pz;

  assign px = in_pt.point_x * in_pt.point_x;
  assign py = in_pt.point_y * in_pt.point_y;
  assign pz = in_pt.point_z * in_pt.point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x_r   <= in_pt.point_x;
      a_y_r   <= in_pt.point_y;
      a_z_r   <= in_pt.point_z;
      a_sqx_r <= $unsigned(px);
      a_sqy_r <= $unsigned(py);
      a_sqz_r <= $unsigned(pz);
    end
  end

  // stage B: sums of squares
  logic                 b_v_r;
  logic signed [CW-1:0] b_x_r, b_y_r, b_z_r;
  logic [RAD_W-1:0]     b_xy2_r, b_r2_r, b_xy2_nxt;

  assign b_xy2_nxt = RAD_W'(a_sqx_r) + RAD_W'(a_sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_x_r   <= a_x_r;
      b_y_r   <= a_y_r;
      b_z_r   <= a_z_r;
      b_xy2_r <= b_xy2_nxt;
      b_r2_r  <= b_xy2_nxt + RAD_W'(a_sqz_r);
    end
  end

  // square roots: full range and horizontal range
  logic              sq_v;
  logic [ROOT_W-1:0] sq_range, sq_rh;
  logic [3*CW-1:0]   sq_sb;

  lrip_isqrt_pipe #(
    .RAD_W (RAD_W),
    .SB_W  (3 * CW)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (b_v_r),
    .rad_a     (b_r2_r),
    .rad_b     (b_xy2_r),
    .sb_in     ({b_x_r, b_y_r, b_z_r}),
    .out_valid (sq_v),
    .root_a    (sq_range),
    .root_b    (sq_rh),
    .sb_out    (sq_sb)
  );

  // angles: lane 0 elevation atan2(z, rh), lane 1 azimuth atan2(x, y)
  logic signed [CW:0] cs0, cc0, cs1, cc1;
  assign cs0 = (CW+1)'($signed(sq_sb[CW-1:0]));
  assign cc0 = $signed(sq_rh);
  assign cs1 = (CW+1)'($signed(sq_sb[3*CW-1:2*CW]));
  assign cc1 = (CW+1)'($signed(sq_sb[2*CW-1:CW]));

  logic                 co_v;
  logic signed [AW-1:0] elev, azim;
  logic [ROOT_W-1:0]    co_range;

  lrip_cordic_pipe #(
    .COORD_WIDTH  (CW),
    .CORDIC_STEPS (CORDIC_STEPS),
    .SB_W         (ROOT_W)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_v),
    .s0_in     (cs0),
    .c0_in     (cc0),
    .s1_in     (cs1),
    .c1_in     (cc1),
    .sb_in     (sq_range),
    .out_valid (co_v),
    .ang0      (elev),
    .ang1      (azim),
    .sb_out    (co_range)
  );

  // stage C: dividends for row and column
  logic signed [AW:0] rsum, dang;
  logic [AW:0]        rmag, dmag;

  assign rsum = (AW+1)'(elev) + (AW+1)'(bottom_offset_r);
  assign dang = (AW+1)'(azim) - (AW+1)'(lrip_pkg::HALF_PI_Q20);
  assign rmag = rsum[AW] ? $unsigned(-rsum) : $unsigned(rsum);
  assign dmag = dang[AW] ? $unsigned(-dang) : $unsigned(dang);

  logic              c_v_r;
  logic [DN-1:0]     c_rdvd_r, c_cdvd_r;
  logic              c_rneg_r, c_dneg_r;
  logic [ROOT_W-1:0] c_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= co_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_rdvd_r  <= DN'(rmag);
      c_cdvd_r  <= DN'({dmag, 1'b0}) + DN'(horizontal_step_r);
      c_rneg_r  <= rsum[AW];
      c_dneg_r  <= dang[AW];
      c_range_r <= co_range;
    end
  end

  // row = |rsum| / vstep, column quotient = (2|d| + h) / 2h
  logic                dv_v;
  logic [DN-1:0]       q_row, q_col;
  logic [ROOT_W+1:0]   dv_sb;

  lrip_div_pipe #(
    .N    (DN),
    .D    (DD),
    .SB_W (ROOT_W + 2)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (c_v_r),
    .dvd0      (c_rdvd_r),
    .dvs0      (DD'(vertical_step_r)),
    .dvd1      (c_cdvd_r),
    .dvs1      ({horizontal_step_r, 1'b0}),
    .sb_in     ({c_range_r, c_rneg_r, c_dneg_r}),
    .out_valid (dv_v),
    .quo0      (q_row),
    .quo1      (q_col),
    .sb_out    (dv_sb)
  );

  // stage D: row check and column numerator cols - 2q, or cols + 2q for a negative offset
  logic              d_v_r;
  logic              d_row_bad_r;
  logic [SW-1:0]     d_cv_r;
  logic [RW-1:0]     d_row_r;
  logic [ROOT_W-1:0] d_range_r;
  logic [DN:0]       q_col2;
  logic              row_bad;

  assign q_col2  = {q_col, 1'b0};
  assign row_bad = (vertical_step_r == '0) || (dv_sb[1] && (q_row != '0)) ||
                   (q_row >= DN'(rows));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_row_bad_r <= row_bad;
      d_cv_r      <= dv_sb[0] ? (SW'(cols) + SW'(q_col2)) : (SW'(cols) - SW'(q_col2));
      d_row_r     <= q_row[RW-1:0];
      d_range_r   <= dv_sb[ROOT_W+1:2];
    end
  end

  // stage E: halve toward zero, wrap once, classify
  logic signed [SW-1:0] cv, col0, col1, cols_s;
  logic                 col_bad;
  logic                 near;
  lrip_pkg::status_t    status_nxt;

  assign cv     = $signed(d_cv_r);
  assign cols_s = $signed(SW'(cols));
  assign col0   = cv[SW-1] ? -((-cv) >>> 1) : (cv >>> 1);
  assign col1   = (col0 >= cols_s) ? (col0 - cols_s) : col0;
  assign col_bad = (horizontal_step_r == '0) || col1[SW-1] || (col1 >= cols_s);
  assign near    = d_range_r < min_range_r;

  always_comb begin
    priority if (d_row_bad_r) begin
      status_nxt = lrip_pkg::ST_ROW_OUT;
    end else if (col_bad) begin
      status_nxt = lrip_pkg::ST_COL_OUT;
    end else if (near) begin
      status_nxt = lrip_pkg::ST_TOO_NEAR;
    end else begin
      status_nxt = lrip_pkg::ST_OK;
    end
  end

  logic              e_v_r;
  lrip_pkg::status_t e_status_r;
  logic [RW-1:0]     e_row_r;
  logic [KW-1:0]     e_col_r;
  logic [ROOT_W-1:0] e_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_status_r <= status_nxt;
      e_row_r    <= d_row_r;
      e_col_r    <= col1[KW-1:0];
      e_range_r  <= d_range_r;
    end
  end

  // final fields: flat cell index, zero the cell fields of a rejected point
  logic [RW+lrip_pkg::COLS_W:0] cell_full;
  assign cell_full = (RW+lrip_pkg::COLS_W+1)'(e_row_r * cols) +
                     (RW+lrip_pkg::COLS_W+1)'(e_col_r);

  always_comb begin
    res_nxt.status = e_status_r;
    res_nxt.range  = lrip_pkg::RANGE_W'(e_range_r);
    if (e_status_r == lrip_pkg::ST_OK) begin
      res_nxt.row        = e_row_r[lrip_pkg::ROW_W-1:0];
      res_nxt.column     = e_col_r[lrip_pkg::COL_W-1:0];
      res_nxt.cell_index = cell_full[lrip_pkg::CELL_W-1:0];
    end else begin
      res_nxt.row        = '0;
      res_nxt.column     = '0;
      res_nxt.cell_index = '0;
    end
  end

  // two-entry output queue
  assign push = adv && e_v_r;
  assign pop  = out_res.valid && out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push && !pop) begin
      cnt_r <= cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        head_r <= res_nxt;
      end else begin
        head_r <= tail_r;
        tail_r <= res_nxt;
      end
    end else if (pop) begin
      head_r <= tail_r;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        head_r <= res_nxt;
      end else begin
        tail_r <= res_nxt;
      end
    end
  end

  assign out_res.valid      = (cnt_r != 2'd0);
  assign out_res.status     = head_r.status;
  assign out_res.row        = head_r.row;
  assign out_res.column     = head_r.column;
  assign out_res.cell_index = head_r.cell_index;
  assign out_res.range      = head_r.range;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue overfilled");

  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pt.ready |-> (cnt_r == 2'd2))
    else $error("input held off with room in the output queue");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && (out_res.status != lrip_pkg::ST_OK)) |->
      ((out_res.row == '0) && (out_res.column == '0) && (out_res.cell_index == '0)))
    else $error("rejected point carries cell fields");

endmodule

@@ rtl/core/lrip_isqrt_pipe.sv @@
// Two-lane pipelined integer square root, one root bit per stage.
module lrip_isqrt_pipe #(
  parameter int RAD_W = 50,
  parameter int SB_W  = 72
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     rad_a,
  input  logic [RAD_W-1:0]     rad_b,
  input  logic [SB_W-1:0]      sb_in,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   root_a,
  output logic [RAD_W/2-1:0]   root_b,
  output logic [SB_W-1:0]      sb_out
);
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int N      = ROOT_W;

  logic              v_r    [N];
  logic [SB_W-1:0]   sb_r   [N];
  logic [RAD_W-1:0]  rad_r  [2][N];
  logic [REM_W-1:0]  rem_r  [2][N];
  logic [ROOT_W-1:0] root_r [2][N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic              cur_v;
    logic [SB_W-1:0]   cur_sb;
    logic [RAD_W-1:0]  cur_rad  [2];
    logic [REM_W-1:0]  cur_rem  [2];
    logic [ROOT_W-1:0] cur_root [2];

    if (k == 0) begin : g_first
      assign cur_v       = in_valid;
      assign cur_sb      = sb_in;
      assign cur_rad[0]  = rad_a;
      assign cur_rad[1]  = rad_b;
      assign cur_rem[0]  = '0;
      assign cur_rem[1]  = '0;
      assign cur_root[0] = '0;
      assign cur_root[1] = '0;
    end else begin : g_next
      assign cur_v       = v_r[k-1];
      assign cur_sb      = sb_r[k-1];
      assign cur_rad[0]  = rad_r[0][k-1];
      assign cur_rad[1]  = rad_r[1][k-1];
      assign cur_rem[0]  = rem_r[0][k-1];
      assign cur_rem[1]  = rem_r[1][k-1];
      assign cur_root[0] = root_r[0][k-1];
      assign cur_root[1] = root_r[1][k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k] <= cur_sb;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [REM_W-1:0]  t;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_nxt;
      logic [ROOT_W-1:0] root_nxt;

      always_comb begin
        t     = {cur_rem[l][REM_W-3:0], cur_rad[l][RAD_W-1 -: 2]};
        trial = {cur_root[l], 2'b01};
        if (t >= trial) begin
          rem_nxt  = t - trial;
          root_nxt = {cur_root[l][ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = t;
          root_nxt = {cur_root[l][ROOT_W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[l][k]  <= cur_rad[l] << 2;
          rem_r[l][k]  <= rem_nxt;
          root_r[l][k] <= root_nxt;
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign sb_out    = sb_r[N-1];
  assign root_a    = root_r[0][N-1];
  assign root_b    = root_r[1][N-1];

endmodule

@@ rtl/core/lrip_cordic_pipe.sv @@
// Two-lane pipelined vectoring CORDIC giving atan2(s, c), one rotation per stage.
module lrip_cordic_pipe #(
  parameter int COORD_WIDTH  = lrip_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = lrip_pkg::CORDIC_STEPS_DEF,
  parameter int SB_W         = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [COORD_WIDTH:0]        s0_in,
  input  logic signed [COORD_WIDTH:0]        c0_in,
  input  logic signed [COORD_WIDTH:0]        s1_in,
  input  logic signed [COORD_WIDTH:0]        c1_in,
  input  logic [SB_W-1:0]                    sb_in,
  output logic                               out_valid,
  output logic signed [lrip_pkg::ANG_W-1:0]  ang0,
  output logic signed [lrip_pkg::ANG_W-1:0]  ang1,
  output logic [SB_W-1:0]                    sb_out
);
  localparam int CW       = lrip_pkg::CORDIC_W;
  localparam int AW       = lrip_pkg::ANG_W;
  localparam int PRESCALE = 61 - COORD_WIDTH;
  localparam int N        = CORDIC_STEPS + 1;

  logic signed [COORD_WIDTH:0] in_s [2];
  logic signed [COORD_WIDTH:0] in_c [2];

  logic                 v_r  [N];
  logic [SB_W-1:0]      sb_r [N];
  logic signed [CW-1:0] s_r  [2][N];
  logic signed [CW-1:0] c_r  [2][N];
  logic signed [AW-1:0] a_r  [2][N];
  logic                 z_r  [2][N];

  assign in_s[0] = s0_in;
  assign in_c[0] = c0_in;
  assign in_s[1] = s1_in;
  assign in_c[1] = c1_in;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic            cur_v;
    logic [SB_W-1:0] cur_sb;

    if (k == 0) begin : g_first
      assign cur_v  = in_valid;
      assign cur_sb = sb_in;
    end else begin : g_next
      assign cur_v  = v_r[k-1];
      assign cur_sb = sb_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k] <= cur_sb;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [CW-1:0] s_nxt;
      logic signed [CW-1:0] c_nxt;
      logic signed [AW-1:0] a_nxt;
      logic                 z_nxt;

      if (k == 0) begin : g_prerot
        logic signed [CW-1:0] ss;
        logic signed [CW-1:0] cc;
        assign ss = CW'(in_s[l]) <<< PRESCALE;
        assign cc = CW'(in_c[l]) <<< PRESCALE;

        // turn a vector in the left half plane by a quarter turn first
        always_comb begin
          z_nxt = (in_s[l] == '0) && (in_c[l] == '0);
          if (cc[CW-1]) begin
            if (!ss[CW-1]) begin
              s_nxt = -cc;
              c_nxt = ss;
              a_nxt = AW'(lrip_pkg::HALF_PI_Q20);
            end else begin
              s_nxt = cc;
              c_nxt = -ss;
              a_nxt = -AW'(lrip_pkg::HALF_PI_Q20);
            end
          end else begin
            s_nxt = ss;
            c_nxt = cc;
            a_nxt = '0;
          end
        end
      end else begin : g_rot
        localparam int SH = k - 1;
        logic signed [CW-1:0] ds;
        logic signed [CW-1:0] dc;
        assign ds = s_r[l][k-1] >>> SH;
        assign dc = c_r[l][k-1] >>> SH;

        always_comb begin
          z_nxt = z_r[l][k-1];
          if (!s_r[l][k-1][CW-1]) begin
            c_nxt = c_r[l][k-1] + ds;
            s_nxt = s_r[l][k-1] - dc;
            a_nxt = a_r[l][k-1] + lrip_pkg::atan_q20(SH);
          end else begin
            c_nxt = c_r[l][k-1] - ds;
            s_nxt = s_r[l][k-1] + dc;
            a_nxt = a_r[l][k-1] - lrip_pkg::atan_q20(SH);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          s_r[l][k] <= s_nxt;
          c_r[l][k] <= c_nxt;
          a_r[l][k] <= a_nxt;
          z_r[l][k] <= z_nxt;
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign sb_out    = sb_r[N-1];
  // a zero vector has angle zero
  assign ang0      = z_r[0][N-1] ? '0 : a_r[0][N-1];
  assign ang1      = z_r[1][N-1] ? '0 : a_r[1][N-1];

endmodule

@@ rtl/core/lrip_div_pipe.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
module lrip_div_pipe #(
  parameter int N    = lrip_pkg::DIV_N,
  parameter int D    = lrip_pkg::DIV_D,
  parameter int SB_W = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [N-1:0]     dvd0,
  input  logic [D-1:0]     dvs0,
  input  logic [N-1:0]     dvd1,
  input  logic [D-1:0]     dvs1,
  input  logic [SB_W-1:0]  sb_in,
  output logic             out_valid,
  output logic [N-1:0]     quo0,
  output logic [N-1:0]     quo1,
  output logic [SB_W-1:0]  sb_out
);
  logic [D-1:0] dvs [2];

  logic            v_r  [N];
  logic [SB_W-1:0] sb_r [N];
  logic [D-1:0]    pr_r [2][N];
  logic [N-1:0]    qd_r [2][N];

  // divisors come from configuration; the user must hold them while items are in flight, the block does not enforce it
  assign dvs[0] = dvs0;
  assign dvs[1] = dvs1;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic            cur_v;
    logic [SB_W-1:0] cur_sb;
    logic [D-1:0]    cur_pr [2];
    logic [N-1:0]    cur_qd [2];

    if (k == 0) begin : g_first
      assign cur_v     = in_valid;
      assign cur_sb    = sb_in;
      assign cur_pr[0] = '0;
      assign cur_pr[1] = '0;
      assign cur_qd[0] = dvd0;
      assign cur_qd[1] = dvd1;
    end else begin : g_next
      assign cur_v     = v_r[k-1];
      assign cur_sb    = sb_r[k-1];
      assign cur_pr[0] = pr_r[0][k-1];
      assign cur_pr[1] = pr_r[1][k-1];
      assign cur_qd[0] = qd_r[0][k-1];
      assign cur_qd[1] = qd_r[1][k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k] <= cur_sb;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [D:0]   t;
      logic [D:0]   diff;
      logic [D-1:0] pr_nxt;
      logic         qbit;

      always_comb begin
        t    = {cur_pr[l], cur_qd[l][N-1]};
        diff = t - {1'b0, dvs[l]};
        qbit = (t >= {1'b0, dvs[l]});
        pr_nxt = qbit ? diff[D-1:0] : t[D-1:0];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pr_r[l][k] <= pr_nxt;
          qd_r[l][k] <= {cur_qd[l][N-2:0], qbit};
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign sb_out    = sb_r[N-1];
  assign quo0      = qd_r[0][N-1];
  assign quo1      = qd_r[1][N-1];

endmodule
